>>> rtl/rpvg_pkg.sv
// shared types and constants for the regular polygon vertex generator
// no dependencies; imported by every module of the block

package rpvg_pkg;

    // field widths that do not follow a parameter
    localparam int RADIUS_BITS = 14;
    localparam int SIDES_BITS  = 7;

    // 2*pi in unsigned q3.30, seed of the per-side-count rotation angle
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } rpvg_state_t;

endpackage

>>> rtl/rpvg_coef_rom.sv
// cosine / sine coefficient table of 2*pi/n, signed q2.FRAC_BITS, registered read
// depends on rpvg_pkg; entries are built at elaboration by a taylor series up to the 24th power

module rpvg_coef_rom
    import rpvg_pkg::*;
#(
    parameter int MAX_SIDES = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [$clog2(MAX_SIDES+1)-1:0]       idx,
    output logic signed [FRAC_BITS+1:0]          cos_coef,
    output logic signed [FRAC_BITS+1:0]          sin_coef
);

    localparam int CW = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;

    logic signed [CW-1:0] cos_tab [MAX_SIDES+1];
    logic signed [CW-1:0] sin_tab [MAX_SIDES+1];

    for (genvar g = 0; g <= MAX_SIDES; g++) begin : g_entry
        // angle in q2.30; counts below three use fixed entries
        localparam longint unsigned TH  = TWO_PI_Q30 / ((g < 3) ? 3 : g);
        localparam longint unsigned T1  = TH;
        localparam longint unsigned T2  = ((T1  * TH) >> 30) / 2;
        localparam longint unsigned T3  = ((T2  * TH) >> 30) / 3;
        localparam longint unsigned T4  = ((T3  * TH) >> 30) / 4;
        localparam longint unsigned T5  = ((T4  * TH) >> 30) / 5;
        localparam longint unsigned T6  = ((T5  * TH) >> 30) / 6;
        localparam longint unsigned T7  = ((T6  * TH) >> 30) / 7;
        localparam longint unsigned T8  = ((T7  * TH) >> 30) / 8;
        localparam longint unsigned T9  = ((T8  * TH) >> 30) / 9;
        localparam longint unsigned T10 = ((T9  * TH) >> 30) / 10;
        localparam longint unsigned T11 = ((T10 * TH) >> 30) / 11;
        localparam longint unsigned T12 = ((T11 * TH) >> 30) / 12;
        localparam longint unsigned T13 = ((T12 * TH) >> 30) / 13;
        localparam longint unsigned T14 = ((T13 * TH) >> 30) / 14;
        localparam longint unsigned T15 = ((T14 * TH) >> 30) / 15;
        localparam longint unsigned T16 = ((T15 * TH) >> 30) / 16;
        localparam longint unsigned T17 = ((T16 * TH) >> 30) / 17;
        localparam longint unsigned T18 = ((T17 * TH) >> 30) / 18;
        localparam longint unsigned T19 = ((T18 * TH) >> 30) / 19;
        localparam longint unsigned T20 = ((T19 * TH) >> 30) / 20;
        localparam longint unsigned T21 = ((T20 * TH) >> 30) / 21;
        localparam longint unsigned T22 = ((T21 * TH) >> 30) / 22;
        localparam longint unsigned T23 = ((T22 * TH) >> 30) / 23;
        localparam longint unsigned T24 = ((T23 * TH) >> 30) / 24;

        localparam longint CA = longint'(64'd1 << 30)
            - longint'(T2)  + longint'(T4)  - longint'(T6)  + longint'(T8)
            - longint'(T10) + longint'(T12) - longint'(T14) + longint'(T16)
            - longint'(T18) + longint'(T20) - longint'(T22) + longint'(T24);
        localparam longint SA = longint'(T1)
            - longint'(T3)  + longint'(T5)  - longint'(T7)  + longint'(T9)
            - longint'(T11) + longint'(T13) - longint'(T15) + longint'(T17)
            - longint'(T19) + longint'(T21) - longint'(T23);

        // round to nearest, ties away from zero
        localparam longint HALF   = longint'(64'd1 << (SH - 1));
        localparam longint CA_MAG = (CA < 0) ? -CA : CA;
        localparam longint SA_MAG = (SA < 0) ? -SA : SA;
        localparam longint CA_R   = (CA_MAG + HALF) >>> SH;
        localparam longint SA_R   = (SA_MAG + HALF) >>> SH;
        localparam longint CA_Q   = (CA < 0) ? -CA_R : CA_R;
        localparam longint SA_Q   = (SA < 0) ? -SA_R : SA_R;

        localparam longint ONE   = longint'(64'd1 << FRAC_BITS);
        localparam longint COS_E = (g <= 1) ? ONE : ((g == 2) ? -ONE : CA_Q);
        localparam longint SIN_E = (g <= 2) ? longint'(0) : SA_Q;

        assign cos_tab[g] = CW'(COS_E);
        assign sin_tab[g] = CW'(SIN_E);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_coef <= cos_tab[idx];
            sin_coef <= sin_tab[idx];
        end
    end

endmodule

>>> rtl/regular_polygon_vertex_gen_unit.sv
// top level of the regular polygon vertex generator
// depends on rpvg_pkg and rpvg_coef_rom
//
// usage
//   slave channel s_*: one beat is one request (center, radius, side count).
//   master channel m_*: one beat per vertex, tlast on the final vertex.
//   a request with n sides (above MAX_SIDES taken as MAX_SIDES) gives n beats;
//   zero sides gives none. the start point sits radius above the center
//   (saturated) and is not sent; each vertex is the previous integer vertex
//   rotated about the center by 2*pi/n.
// timing
//   s_tready is high only while idle, so one request is worked at a time.
//   one multiplier is shared by the four products of a vertex: the product
//   steps, a step for the last accumulate, and an emit step that rounds
//   toward zero, saturates and loads the output register. m_tvalid rises
//   once the emit step of the first vertex has loaded the output register.
//   a new request is taken as soon as the last vertex sits in the output
//   register, even if it has not been taken yet.
// reset and stall
//   rst_n clears the sequencer and output valid; no table clearing is needed.
//   a stalled receiver holds the output beat and the sequencer waits in the
//   emit step until the output register frees up.

module regular_polygon_vertex_gen_unit
    import rpvg_pkg::*;
#(
    parameter int MAX_SIDES  = 64,
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, radius, sides (lowest bit up), zero padded
    input  logic [((2*COORD_BITS+RADIUS_BITS+SIDES_BITS+7)/8)*8-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // vertex_x, vertex_y (lowest bit up), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // last_vertex
    output logic m_tlast
);

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = ((2*C + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(MAX_SIDES + 1);
    localparam int CW     = FRAC_BITS + 2;           // coefficient width
    localparam int DW     = C + 1;                   // delta width
    localparam int PW     = CW + DW;                 // product width
    localparam int AW     = PW + 2;                  // accumulator width
    localparam int QW     = AW - FRAC_BITS;          // integer part width
    localparam int SW     = C + RADIUS_BITS + 1;     // start point difference width
    localparam int RAD_LO = 2*C;
    localparam int SID_LO = 2*C + RADIUS_BITS;

    // saturate a wider signed value to C bits
    function automatic logic [C-1:0] sat_q(input logic [QW-1:0] v);
        logic all_same;
        all_same = (v[QW-1:C-1] == {(QW-C+1){1'b0}}) || (v[QW-1:C-1] == {(QW-C+1){1'b1}});
        if (all_same)
            return v[C-1:0];
        else
            return v[QW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    endfunction

    function automatic logic [C-1:0] sat_s(input logic [SW-1:0] v);
        logic all_same;
        all_same = (v[SW-1:C-1] == {(SW-C+1){1'b0}}) || (v[SW-1:C-1] == {(SW-C+1){1'b1}});
        if (all_same)
            return v[C-1:0];
        else
            return v[SW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    endfunction

    // truncate toward zero by 2^FRAC_BITS, then saturate
    function automatic logic [C-1:0] round_sat(input logic [AW-1:0] a);
        logic [QW-1:0] q;
        logic          fix;
        fix = a[AW-1] && (a[FRAC_BITS-1:0] != '0);
        q   = a[AW-1:FRAC_BITS] + QW'(fix);
        return sat_q(q);
    endfunction

    rpvg_state_t state_reg, state_next;
    logic [2:0]           step_reg, step_next;
    logic [IDX_W-1:0]     remain_reg, remain_next;
    logic signed [C-1:0]  pivot_x_reg, pivot_x_next;
    logic signed [C-1:0]  pivot_y_reg, pivot_y_next;
    logic signed [C-1:0]  cur_x_reg, cur_x_next;
    logic signed [C-1:0]  cur_y_reg, cur_y_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_x_reg, acc_x_next;
    logic signed [AW-1:0] acc_y_reg, acc_y_next;
    logic                 out_valid_reg, out_valid_next;
    logic [C-1:0]         out_x_reg, out_x_next;
    logic [C-1:0]         out_y_reg, out_y_next;
    logic                 out_last_reg, out_last_next;

    logic                 in_beat;
    logic [C-1:0]         in_cx, in_cy;
    logic [RADIUS_BITS-1:0] in_rad;
    logic [SIDES_BITS-1:0]  in_sides, sides_clamped;
    logic [IDX_W-1:0]     rom_idx;
    logic signed [CW-1:0] cos_coef, sin_coef;
    logic signed [DW-1:0] dx, dy;
    logic signed [CW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [AW-1:0] add_base, add_prod, add_sum;
    logic [SW-1:0]        start_diff;
    logic                 out_free;

    assign in_beat  = s_tvalid && s_tready;
    assign in_cx    = s_tdata[C-1:0];
    assign in_cy    = s_tdata[2*C-1:C];
    assign in_rad   = s_tdata[RAD_LO+RADIUS_BITS-1:RAD_LO];
    assign in_sides = s_tdata[SID_LO+SIDES_BITS-1:SID_LO];

    // side counts above the table depth fold onto the top entry
    assign sides_clamped = (in_sides > SIDES_BITS'(MAX_SIDES)) ? SIDES_BITS'(MAX_SIDES)
                                                               : in_sides;
    assign rom_idx = sides_clamped[IDX_W-1:0];

    rpvg_coef_rom #(
        .MAX_SIDES (MAX_SIDES),
        .FRAC_BITS (FRAC_BITS)
    ) u_coef_rom (
        .clk      (clk),
        .en       (in_beat),
        .idx      (rom_idx),
        .cos_coef (cos_coef),
        .sin_coef (sin_coef)
    );

    // start point: center_y - radius, saturated
    assign start_diff = {{(SW-C){in_cy[C-1]}}, in_cy} - SW'(in_rad);

    // offsets of the previous vertex from the center
    assign dx = {cur_x_reg[C-1], cur_x_reg} - {pivot_x_reg[C-1], pivot_x_reg};
    assign dy = {cur_y_reg[C-1], cur_y_reg} - {pivot_y_reg[C-1], pivot_y_reg};

    // shared multiplier operands:
    //   step 0 cos*dx, step 1 sin*dy, step 2 sin*dx, step 3 cos*dy
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = cos_coef; mul_b = dx; end
            3'd1:    begin mul_a = sin_coef; mul_b = dy; end
            3'd2:    begin mul_a = sin_coef; mul_b = dx; end
            3'd3:    begin mul_a = cos_coef; mul_b = dy; end
            default: begin mul_a = cos_coef; mul_b = dy; end
        endcase
    end

    assign prod_next = PW'(mul_a * mul_b);

    // shared adder: the product of the previous step lands on a base
    //   step 1 acc_x = cx<<F + cos*dx, step 2 acc_x -= sin*dy
    //   step 3 acc_y = cy<<F + sin*dx, step 4 acc_y += cos*dy
    always_comb
    begin
        add_prod = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        case (step_reg)
            3'd1:    add_base = {{(AW-C-FRAC_BITS){pivot_x_reg[C-1]}}, pivot_x_reg,
                                 {FRAC_BITS{1'b0}}};
            3'd2:    add_base = acc_x_reg;
            3'd3:    add_base = {{(AW-C-FRAC_BITS){pivot_y_reg[C-1]}}, pivot_y_reg,
                                 {FRAC_BITS{1'b0}}};
            default: add_base = acc_y_reg;
        endcase
        add_sum = (step_reg == 3'd2) ? add_base - add_prod : add_base + add_prod;
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        remain_next    = remain_reg;
        pivot_x_next   = pivot_x_reg;
        pivot_y_next   = pivot_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    pivot_x_next = in_cx;
                    pivot_y_next = in_cy;
                    cur_x_next   = in_cx;
                    cur_y_next   = sat_s(start_diff);
                    remain_next  = rom_idx;
                    step_next    = 3'd0;
                    // zero sides: nothing to send
                    state_next   = (rom_idx == '0) ? ST_IDLE : ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (step_reg == 3'd1 || step_reg == 3'd2)
                    acc_x_next = add_sum;
                if (step_reg == 3'd3 || step_reg == 3'd4)
                    acc_y_next = add_sum;
                if (step_reg == 3'd4)
                    state_next = ST_EMIT;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_x_next     = round_sat(acc_x_reg);
                    out_y_next     = round_sat(acc_y_reg);
                    out_last_next  = (remain_reg == IDX_W'(1));
                    out_valid_next = 1'b1;
                    cur_x_next     = round_sat(acc_x_reg);
                    cur_y_next     = round_sat(acc_y_reg);
                    remain_next    = remain_reg - IDX_W'(1);
                    step_next      = 3'd0;
                    state_next     = (remain_reg == IDX_W'(1)) ? ST_IDLE : ST_CALC;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        pivot_x_reg  <= pivot_x_next;
        pivot_y_reg  <= pivot_y_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        prod_reg     <= prod_next;
        acc_x_reg    <= acc_x_next;
        acc_y_reg    <= acc_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_y_reg, out_x_reg});
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/rpvg_checker.sv
// port-level checks for the regular polygon vertex generator, bound to the top
// depends on rpvg_pkg and regular_polygon_vertex_gen_unit

module rpvg_checker
    import rpvg_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [((2*COORD_BITS+RADIUS_BITS+SIDES_BITS+7)/8)*8-1:0] s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    input logic                                 m_tlast
);

    localparam int SID_LO = 2*COORD_BITS + RADIUS_BITS;

    // one request at a time: the input side closes right after a beat with sides
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata[SID_LO +: SIDES_BITS] != '0)) |=> !s_tready)
        else $error("input accepted a beat while a request was in flight");

    // a vertex that is not the last means the polygon is still running
    a_busy_mid_polygon: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready while a polygon is still being emitted");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind regular_polygon_vertex_gen_unit rpvg_checker #(
    .COORD_BITS (COORD_BITS)
) u_rpvg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
